FILE: rtl/pscl_pkg.sv
// Shared types and constants of the per-source connection limiter.
// Used by the channel interfaces, the table module and the top level.
package pscl_pkg;

	localparam int ENTRIES   = 64;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int ADDR_W    = 32;
	localparam int CNT_W     = 10;
	localparam int CNT_MAX   = (1 << CNT_W) - 1;
	localparam int TOTAL_W   = 16;
	localparam int TOTAL_SAT = (1 << TOTAL_W) - 1;
	localparam int TOT_SUM_W = $clog2(ENTRIES * CNT_MAX + 1);
	localparam int TOT_W     = (TOT_SUM_W > TOTAL_W) ? TOT_SUM_W : TOTAL_W + 1;
	localparam int MAX_RESET = 8;

	typedef enum logic {
		FUNC_CONNECT    = 1'b0,
		FUNC_DISCONNECT = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  cnt;
	} entry_t;

	// Outcome of one full pass over the table.
	typedef struct packed {
		logic             done;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic [CNT_W-1:0] hit_cnt;
		logic             free;
		logic [IDX_W-1:0] free_idx;
	} lookup_t;

	// Write-back of one entry and its valid bit.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		entry_t           data;
		logic             set_valid;
		logic             clr_valid;
	} write_t;

endpackage

FILE: rtl/pscl_if.sv
// Handshake channel interfaces of the per-source connection limiter.
// Depends on pscl_pkg for field widths.
interface pscl_evt_if;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [pscl_pkg::ADDR_W-1:0] source_addr;

	modport source (output valid, func, source_addr, input ready);
	modport sink (input valid, func, source_addr, output ready);
endinterface

interface pscl_res_if;
	logic                          valid;
	logic                          ready;
	logic                          accepted;
	logic                          released;
	logic                          found;
	logic [pscl_pkg::CNT_W-1:0]   count;
	logic [pscl_pkg::TOTAL_W-1:0] total;
	logic                          table_full;

	modport source (output valid, accepted, released, found, count, total, table_full,
		input ready);
	modport sink (input valid, accepted, released, found, count, total, table_full,
		output ready);
endinterface

interface pscl_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [pscl_pkg::CNT_W-1:0] max_per_source;

	modport source (output valid, max_per_source, input ready);
	modport sink (input valid, max_per_source, output ready);
endinterface

FILE: rtl/pscl_table.sv
// Address/count table with valid bits and a sequential search engine.
// Depends on pscl_pkg for entry, lookup and write-back types.
module pscl_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pscl_pkg::ADDR_W-1:0] key,
	output pscl_pkg::lookup_t           lkp,
	input  pscl_pkg::write_t            wr
);

	localparam int IW = pscl_pkg::IDX_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(pscl_pkg::ENTRIES - 1);

	pscl_pkg::entry_t mem [pscl_pkg::ENTRIES];
	logic [pscl_pkg::ENTRIES-1:0] valid_q;

	logic          issuing_q;
	logic [IW-1:0] rd_idx_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	pscl_pkg::entry_t rd_data_s1;

	logic                       done_q;
	logic                       hit_q;
	logic [IW-1:0]              hit_idx_q;
	logic [pscl_pkg::CNT_W-1:0] hit_cnt_q;
	logic                       free_q;
	logic [IW-1:0]              free_idx_q;

	logic match;
	logic empty;

	// Memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		rd_data_s1 <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			if (wr.set_valid) begin
				valid_q[wr.idx] <= 1'b1;
			end else if (wr.clr_valid) begin
				valid_q[wr.idx] <= 1'b0;
			end
		end
	end

	// Read address sequencer walks every entry once per search.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			rd_vld_s1 <= issuing_q;
			rd_idx_s1 <= rd_idx_q;
			if (start) begin
				issuing_q <= 1'b1;
				rd_idx_q  <= '0;
			end else if (issuing_q) begin
				if (rd_idx_q == LAST_IDX) begin
					issuing_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		match = rd_vld_s1 && valid_q[rd_idx_s1] && (rd_data_s1.addr == key);
		empty = rd_vld_s1 && !valid_q[rd_idx_s1];
	end

	// Keep the matching entry and the lowest free entry seen so far.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			hit_cnt_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
		end else begin
			done_q <= rd_vld_s1 && (rd_idx_s1 == LAST_IDX);
			if (start) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (match && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= rd_idx_s1;
					hit_cnt_q <= rd_data_s1.cnt;
				end
				if (empty && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= rd_idx_s1;
				end
			end
		end
	end

	always_comb begin
		lkp.done     = done_q;
		lkp.hit      = hit_q;
		lkp.hit_idx  = hit_idx_q;
		lkp.hit_cnt  = hit_cnt_q;
		lkp.free     = free_q;
		lkp.free_idx = free_idx_q;
	end

	a_hit_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && hit_q |-> valid_q[hit_idx_q])
		else $error("search hit points at an invalid entry");

	a_free_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && free_q |-> !valid_q[free_idx_q])
		else $error("free entry reported for a valid slot");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("search done held for more than one cycle");

endmodule

FILE: rtl/per_source_connection_limiter.sv
// Top level of the per-source connection limiter.
// Depends on pscl_pkg, the channel interfaces in pscl_if and pscl_table.

// Each event item on evt is a connect or a disconnect for one IPv4 source
// address, and yields exactly one result item on res with the address's
// count after the event and the running total over all sources. The block
// handles one event at a time: after an item is accepted, the table search
// reads every one of the ENTRIES slots from a single-port-read memory, one
// slot per cycle, and then performs the update, so a new event is taken only
// once the previous one has passed its update. The event rate is set by the
// memory read port that the linear search walks. The result sits in an output
// register, so a stalled res channel does not block the search of the next
// item; only the write-back waits for the register to free up. The limit
// max_per_source (reset 8) is written through cfg, which is always ready, and
// should only be changed while no event is in flight. A new address is
// admitted with count 1 even when the limit is 0, a full table refuses new
// addresses with table_full, and total saturates at its field width.
module per_source_connection_limiter (
	input logic        clk,
	input logic        arst_n,
	pscl_evt_if.sink   evt,
	pscl_res_if.source res,
	pscl_cfg_if.sink   cfg
);

	localparam int CW = pscl_pkg::CNT_W;
	localparam int TW = pscl_pkg::TOT_W;
	localparam int OW = pscl_pkg::TOTAL_W;

	pscl_pkg::state_t  state_q;
	pscl_pkg::state_t  state_nxt;
	pscl_pkg::func_t   func_q;
	logic [pscl_pkg::ADDR_W-1:0] addr_q;
	logic [CW-1:0]     max_q;
	logic [TW-1:0]     total_q;

	pscl_pkg::lookup_t lkp;
	pscl_pkg::write_t  wr;

	logic evt_take;
	logic upd_go;

	// Result computed in the update cycle.
	logic          r_acc;
	logic          r_rel;
	logic [CW-1:0] r_cnt;
	logic          r_full;
	logic [TW-1:0] total_nxt;

	// Output register.
	logic          res_valid_q;
	logic          acc_q;
	logic          rel_q;
	logic          found_q;
	logic [CW-1:0] cnt_q;
	logic [OW-1:0] tot_q;
	logic          full_q;

	pscl_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (evt_take),
		.key    (addr_q),
		.lkp    (lkp),
		.wr     (wr)
	);

	// The limit register is the only configuration state.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= CW'(pscl_pkg::MAX_RESET);
		end else if (cfg.valid) begin
			max_q <= cfg.max_per_source;
		end
	end

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pscl_pkg::ST_IDLE: begin
				if (evt.valid) begin
					state_nxt = pscl_pkg::ST_SCAN;
				end
			end
			pscl_pkg::ST_SCAN: begin
				if (lkp.done) begin
					state_nxt = pscl_pkg::ST_UPDATE;
				end
			end
			pscl_pkg::ST_UPDATE: begin
				if (!res_valid_q || res.ready) begin
					state_nxt = pscl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = pscl_pkg::ST_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		evt.ready = 1'b0;
		upd_go    = 1'b0;
		case (state_q)
			pscl_pkg::ST_IDLE: begin
				evt.ready = 1'b1;
			end
			pscl_pkg::ST_UPDATE: begin
				upd_go = !res_valid_q || res.ready;
			end
			default: begin
				evt.ready = 1'b0;
				upd_go    = 1'b0;
			end
		endcase
	end

	assign evt_take = evt.valid && evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pscl_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// The event is held for the whole search; the table compares against addr_q.
	always_ff @(posedge clk) begin
		if (evt_take) begin
			func_q <= pscl_pkg::func_t'(evt.func);
			addr_q <= evt.source_addr;
		end
	end

	// Event semantics, applied once the search has found the entry (if any)
	// and the lowest free slot.
	always_comb begin
		r_acc          = 1'b0;
		r_rel          = 1'b0;
		r_cnt          = '0;
		r_full         = 1'b0;
		total_nxt      = total_q;
		wr.en          = 1'b0;
		wr.idx         = lkp.hit_idx;
		wr.data.addr   = addr_q;
		wr.data.cnt    = lkp.hit_cnt;
		wr.set_valid   = 1'b0;
		wr.clr_valid   = 1'b0;
		if (func_q == pscl_pkg::FUNC_CONNECT) begin
			if (lkp.hit) begin
				r_cnt = lkp.hit_cnt;
				if (lkp.hit_cnt < max_q) begin
					r_cnt       = lkp.hit_cnt + 1'b1;
					r_acc       = 1'b1;
					total_nxt   = total_q + 1'b1;
					wr.en       = upd_go;
					wr.data.cnt = r_cnt;
				end
			end else if (lkp.free) begin
				r_cnt        = CW'(1);
				r_acc        = 1'b1;
				total_nxt    = total_q + 1'b1;
				wr.en        = upd_go;
				wr.idx       = lkp.free_idx;
				wr.data.cnt  = CW'(1);
				wr.set_valid = 1'b1;
			end else begin
				r_full = 1'b1;
			end
		end else begin
			if (lkp.hit) begin
				r_cnt = lkp.hit_cnt;
				if (lkp.hit_cnt != '0) begin
					r_cnt     = lkp.hit_cnt - 1'b1;
					total_nxt = total_q - 1'b1;
				end
				wr.en        = upd_go;
				wr.data.cnt  = r_cnt;
				wr.clr_valid = (r_cnt == '0);
			end
			r_rel = (r_cnt == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (upd_go) begin
				total_q     <= total_nxt;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			acc_q   <= r_acc;
			rel_q   <= r_rel;
			found_q <= lkp.hit;
			cnt_q   <= r_cnt;
			full_q  <= r_full;
			if (total_nxt > TW'(pscl_pkg::TOTAL_SAT)) begin
				tot_q <= OW'(pscl_pkg::TOTAL_SAT);
			end else begin
				tot_q <= total_nxt[OW-1:0];
			end
		end
	end

	assign res.valid      = res_valid_q;
	assign res.accepted   = acc_q;
	assign res.released   = rel_q;
	assign res.found      = found_q;
	assign res.count      = cnt_q;
	assign res.total      = tot_q;
	assign res.table_full = full_q;

	a_write_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> state_q == pscl_pkg::ST_UPDATE && lkp.done == 1'b0)
		else $error("table written outside the update cycle");

	a_result_follows_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == pscl_pkg::ST_UPDATE)
		else $error("result raised without an update");

	a_acc_full_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(acc_q && full_q) && !(acc_q && rel_q) && (!acc_q || cnt_q != '0))
		else $error("inconsistent result flags");

endmodule

FILE: tb/sv/per_source_connection_limiter_tb.sv
// Self-checking testbench of the per-source connection limiter.
// Depends on pscl_pkg, the channel interfaces in pscl_if and the block itself.
// A scripted opening is followed by random event mixes under three idling modes.
module per_source_connection_limiter_tb;
	import pscl_pkg::*;

	// The run is stopped as failed if it has not finished after this many cycles.
	localparam int CYCLE_LIMIT = 1000000;
	// How long the result side refuses results when the stimulus asks for a hold.
	localparam int HOLD_CYCLES = 600;

	// One result item, in the order of the result channel's fields.
	typedef struct packed {
		logic               accepted;
		logic               released;
		logic               found;
		logic [CNT_W-1:0]   count;
		logic [TOTAL_W-1:0] total;
		logic               table_full;
	} outcome_t;

	typedef enum logic {
		ROW_EVENT,
		ROW_LIMIT
	} row_kind_t;

	// One row of the opening script. A row either sends an event or writes the
	// limit. Where typed is set, the result is written out in the row; otherwise
	// the predictor supplies it.
	typedef struct packed {
		row_kind_t         kind;
		func_t             func;
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  limit;
		logic              typed;
		outcome_t          want;
	} script_row_t;

	localparam script_row_t OPENING [0:24] = '{
		// Disconnect of an address that was never seen: released, nothing found.
		'{ROW_EVENT, FUNC_DISCONNECT, 32'h0000_0000, 10'd0, 1'b1,
			'{1'b0, 1'b1, 1'b0, 10'd0, 16'd0, 1'b0}},
		// First connects of the lowest and highest addresses start at count 1.
		'{ROW_EVENT, FUNC_CONNECT, 32'h0000_0000, 10'd0, 1'b1,
			'{1'b1, 1'b0, 1'b0, 10'd1, 16'd1, 1'b0}},
		'{ROW_EVENT, FUNC_CONNECT, 32'hFFFF_FFFF, 10'd0, 1'b1,
			'{1'b1, 1'b0, 1'b0, 10'd1, 16'd2, 1'b0}},
		'{ROW_EVENT, FUNC_CONNECT, 32'hFFFF_FFFF, 10'd0, 1'b0, '0},
		'{ROW_EVENT, FUNC_CONNECT, 32'h0000_0000, 10'd0, 1'b0, '0},
		// Count down to zero, then once more on the now absent address.
		'{ROW_EVENT, FUNC_DISCONNECT, 32'hFFFF_FFFF, 10'd0, 1'b0, '0},
		'{ROW_EVENT, FUNC_DISCONNECT, 32'hFFFF_FFFF, 10'd0, 1'b0, '0},
		'{ROW_EVENT, FUNC_DISCONNECT, 32'hFFFF_FFFF, 10'd0, 1'b0, '0},
		// With the limit at zero a new address still gets in with count 1,
		// and the address that is already above the limit is refused.
		'{ROW_LIMIT, FUNC_CONNECT, 32'h0000_0000, 10'd0, 1'b0, '0},
		'{ROW_EVENT, FUNC_CONNECT, 32'hA5A5_A5A5, 10'd0, 1'b0, '0},
		'{ROW_EVENT, FUNC_CONNECT, 32'hA5A5_A5A5, 10'd0, 1'b0, '0},
		'{ROW_EVENT, FUNC_CONNECT, 32'h0000_0000, 10'd0, 1'b0, '0},
		'{ROW_EVENT, FUNC_DISCONNECT, 32'h0000_0000, 10'd0, 1'b0, '0},
		'{ROW_EVENT, FUNC_CONNECT, 32'h0000_0000, 10'd0, 1'b0, '0},
		// Largest limit.
		'{ROW_LIMIT, FUNC_CONNECT, 32'h0000_0000, 10'd1023, 1'b0, '0},
		'{ROW_EVENT, FUNC_CONNECT, 32'h5A5A_5A5A, 10'd0, 1'b0, '0},
		'{ROW_EVENT, FUNC_CONNECT, 32'h5A5A_5A5A, 10'd0, 1'b0, '0},
		'{ROW_EVENT, FUNC_CONNECT, 32'hA5A5_A5A5, 10'd0, 1'b0, '0},
		// Limit lowered below a live count.
		'{ROW_LIMIT, FUNC_CONNECT, 32'h0000_0000, 10'd1, 1'b0, '0},
		'{ROW_EVENT, FUNC_CONNECT, 32'h5A5A_5A5A, 10'd0, 1'b0, '0},
		'{ROW_EVENT, FUNC_DISCONNECT, 32'h5A5A_5A5A, 10'd0, 1'b0, '0},
		'{ROW_EVENT, FUNC_DISCONNECT, 32'h5A5A_5A5A, 10'd0, 1'b0, '0},
		'{ROW_EVENT, FUNC_DISCONNECT, 32'hA5A5_A5A5, 10'd0, 1'b0, '0},
		'{ROW_EVENT, FUNC_DISCONNECT, 32'hA5A5_A5A5, 10'd0, 1'b0, '0},
		'{ROW_EVENT, FUNC_DISCONNECT, 32'h0000_0000, 10'd0, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	pscl_evt_if evt_ch ();
	pscl_res_if res_ch ();
	pscl_cfg_if cfg_ch ();

	per_source_connection_limiter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// Predictor state: a copy of the source table, the running total and the
	// limit as the block should hold them after every accepted item.
	logic [ADDR_W-1:0] slot_addr [ENTRIES];
	logic [CNT_W-1:0]  slot_count [ENTRIES];
	bit                slot_used [ENTRIES];
	int unsigned       live_total;
	logic [CNT_W-1:0]  limit_now;

	// Results the block still owes, oldest first.
	outcome_t pending_results [$];
	// Addresses that the random mixes mostly draw from, so that the same
	// sources come back often enough to reach their limits and to be freed.
	logic [ADDR_W-1:0] addr_pool [$];

	int unsigned mismatches   = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count  = 0;

	// Idling of the two sides, in percent of cycles.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// A long hold on the result side is asked for by bumping hold_asks; the
	// receiver process notices the change and counts the hold out itself.
	int unsigned hold_asks  = 0;
	int unsigned hold_taken = 0;
	int unsigned hold_left  = 0;

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		mismatches++;
		if (mismatches <= 200) begin
			$display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
		end
	endtask

	// Works out the result of one event and moves the table copy along. The
	// lookup returns the lowest matching slot, and a new address takes the
	// lowest free slot.
	function automatic outcome_t predict_event(func_t f, logic [ADDR_W-1:0] a);
		outcome_t o;
		int       hit;
		int       free_slot;
		int       i;
		o = '0;
		hit = -1;
		free_slot = -1;
		for (i = 0; i < ENTRIES; i++) begin
			if (slot_used[i] && slot_addr[i] == a && hit < 0) begin
				hit = i;
			end
			if (!slot_used[i] && free_slot < 0) begin
				free_slot = i;
			end
		end
		o.found = (hit >= 0);
		if (f == FUNC_CONNECT) begin
			if (hit >= 0) begin
				// A known source is counted only while it is below the limit.
				if (slot_count[hit] < limit_now) begin
					slot_count[hit] = slot_count[hit] + 1'b1;
					live_total++;
					o.accepted = 1'b1;
				end
				o.count = slot_count[hit];
			end else if (free_slot < 0) begin
				// No room for a new source: refused, nothing changes.
				o.table_full = 1'b1;
			end else begin
				// A new source always starts at one, whatever the limit.
				slot_addr[free_slot] = a;
				slot_count[free_slot] = CNT_W'(1);
				slot_used[free_slot] = 1'b1;
				live_total++;
				o.count = CNT_W'(1);
				o.accepted = 1'b1;
			end
		end else begin
			if (hit >= 0) begin
				if (slot_count[hit] > 0) begin
					slot_count[hit] = slot_count[hit] - 1'b1;
					live_total--;
				end
				o.count = slot_count[hit];
				if (slot_count[hit] == 0) begin
					slot_used[hit] = 1'b0;
				end
			end
			// An absent source counts as released as well.
			o.released = (o.count == 0);
		end
		o.total = TOTAL_W'((live_total > TOTAL_SAT) ? TOTAL_SAT : live_total);
		return o;
	endfunction

	// Offers one event, starting at a falling edge, and returns at the falling
	// edge after it was taken. The valid line is left high, so back-to-back
	// items keep it up; it only drops when the sender idles or pauses.
	task automatic send_event(func_t f, logic [ADDR_W-1:0] a, bit typed = 1'b0,
		outcome_t want = '0);
		outcome_t guess;
		while ($urandom_range(99) < send_idle_pct) begin
			evt_ch.valid <= 1'b0;
			@(negedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.func <= f;
		evt_ch.source_addr <= a;
		do @(posedge clk); while (!evt_ch.ready);
		guess = predict_event(f, a);
		pending_results.push_back(typed ? want : guess);
		@(negedge clk);
	endtask

	// Stops offering items and waits until every result owed has come in.
	// Every event yields a result, so at that point the block is idle.
	task automatic wait_results_drained();
		evt_ch.valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_limit(logic [CNT_W-1:0] v);
		wait_results_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.max_per_source <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		limit_now = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_idling(int sender_pct, int receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct <= receiver_pct;
	endtask

	// Random events, mostly on pooled sources. Some disconnects go to fresh
	// random addresses, which are nearly always absent; those also toggle
	// every address bit.
	task automatic run_mix(int n);
		int                k;
		func_t             f;
		logic [ADDR_W-1:0] a;
		for (k = 0; k < n; k++) begin
			f = ($urandom_range(99) < 58) ? FUNC_CONNECT : FUNC_DISCONNECT;
			if (f == FUNC_DISCONNECT && $urandom_range(99) < 12) begin
				a = $urandom;
			end else begin
				a = addr_pool[$urandom_range(addr_pool.size() - 1)];
			end
			send_event(f, a);
		end
	endtask

	// Disconnects every live source until the table is empty.
	task automatic release_all_sources();
		int i;
		for (i = 0; i < ENTRIES; i++) begin
			while (slot_used[i]) begin
				send_event(FUNC_DISCONNECT, slot_addr[i]);
			end
		end
	endtask

	task automatic check_outcome(outcome_t seen);
		outcome_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			report_mismatch("number of items awaiting a result", 0, 1);
		end else begin
			want = pending_results.pop_front();
			if (seen.accepted !== want.accepted)
				report_mismatch("accepted", 32'(seen.accepted), 32'(want.accepted));
			if (seen.released !== want.released)
				report_mismatch("released", 32'(seen.released), 32'(want.released));
			if (seen.found !== want.found)
				report_mismatch("found", 32'(seen.found), 32'(want.found));
			if (seen.count !== want.count)
				report_mismatch("count", 32'(seen.count), 32'(want.count));
			if (seen.total !== want.total)
				report_mismatch("total", 32'(seen.total), 32'(want.total));
			if (seen.table_full !== want.table_full)
				report_mismatch("table_full", 32'(seen.table_full),
					32'(want.table_full));
		end
	endtask

	// Result side: ready changes at the falling edge only. A requested hold
	// keeps ready low for a long stretch so that the block backs up.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res_ch.ready <= 1'b0;
		end else if (hold_asks != hold_taken) begin
			hold_taken = hold_asks;
			hold_left = HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Results are taken at the rising edge, from the values before the edge.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			check_outcome({res_ch.accepted, res_ch.released, res_ch.found,
				res_ch.count, res_ch.total, res_ch.table_full});
		end
	end

	// Watchdog: a stuck handshake or a lost result ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("per_source_connection_limiter: mismatch");
		$finish;
	end

	initial begin
		int                r;
		logic [ADDR_W-1:0] a;

		arst_n = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.func = FUNC_CONNECT;
		evt_ch.source_addr = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.max_per_source = '0;

		for (r = 0; r < ENTRIES; r++) begin
			slot_used[r] = 1'b0;
			slot_addr[r] = '0;
			slot_count[r] = '0;
		end
		live_total = 0;
		limit_now = CNT_W'(MAX_RESET);

		// The pool holds both address extremes and a couple of dozen random
		// sources, well under the table size, so the mixes rarely fill it.
		addr_pool.push_back(32'h0000_0000);
		addr_pool.push_back(32'hFFFF_FFFF);
		repeat (22) addr_pool.push_back($urandom);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Sender idles a little, receiver a lot.
		set_idling(20, 78);

		for (r = 0; r < $size(OPENING); r++) begin
			if (OPENING[r].kind == ROW_LIMIT) begin
				write_limit(OPENING[r].limit);
			end else begin
				send_event(OPENING[r].func, OPENING[r].addr, OPENING[r].typed,
					OPENING[r].want);
			end
		end

		// Small limit, so refusals are frequent.
		write_limit(CNT_W'(3));
		run_mix(40);

		// Fill the table with fresh sources until new ones are refused as full,
		// keep going with pooled traffic while it is full, then empty it.
		write_limit(CNT_W'(2));
		repeat (ENTRIES + 6) send_event(FUNC_CONNECT, $urandom);
		run_mix(10);
		release_all_sources();

		// Sender idles a lot, receiver a little.
		set_idling(78, 20);
		write_limit(CNT_W'($urandom_range(1, 6)));
		run_mix(40);

		// Drive one source up to the largest count the field can hold, with
		// the limit at its top, and past it so the last connects are refused.
		write_limit(CNT_W'(CNT_MAX));
		a = $urandom;
		addr_pool.push_back(a);
		repeat (CNT_MAX + 2) send_event(FUNC_CONNECT, a);
		repeat (3) send_event(FUNC_DISCONNECT, a);

		// No idling on either side. Partway through, the receiver holds off
		// long enough for the block to stall its input while items keep
		// coming; later the sender pauses until every result is in.
		set_idling(0, 0);
		write_limit(CNT_W'(5));
		run_mix(10);
		hold_asks <= hold_asks + 1;
		run_mix(30);
		wait_results_drained();
		run_mix(10);

		// Let any stray result show up before the verdict.
		wait_results_drained();
		repeat (ENTRIES + 8) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("per_source_connection_limiter: match");
		end else begin
			$display("per_source_connection_limiter: mismatch");
		end
		$finish;
	end

endmodule
